[rtl/sthr_pkg.sv]
// shared types and constants of the serial throttle with deadman ramp
// used by sthr_front, sthr_back and the top level; depends on nothing
package sthr_pkg;

    localparam int TEXT_DEPTH  = 15;
    localparam int RAMP_STEPS  = 20;
    localparam int QUEUE_DEPTH = 2;

    localparam int CNT_W    = $clog2(TEXT_DEPTH + 1);
    localparam int IDX_W    = $clog2(TEXT_DEPTH);
    localparam int STEP_W   = $clog2(RAMP_STEPS + 1);
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int MAG_W    = 7 + STEP_W;
    localparam int PROD_W   = MAG_W + 1;
    localparam int MCALC_W  = 10;

    localparam int TIMEOUT_W   = 16;
    localparam int STEP_TICK_W = 10;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_W       = 24;

    localparam logic [CFG_IDX_W-1:0]   REG_TIMEOUT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0]   REG_RAMP_STEP = 1'd1;
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET = 16'd3000;
    localparam logic [STEP_TICK_W-1:0] STEP_RESET    = 10'd25;
    localparam logic [TIMEOUT_W-1:0]   IDLE_MAX      = 16'hFFFF;

    localparam logic [10:0] NEUTRAL_US = 11'd1500;
    localparam logic [6:0]  MAG_MAX    = 7'd100;
    localparam logic [6:0]  MAG_SAT    = 7'd101;
    localparam logic [3:0]  MINUS_CODE = 4'd10;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_DEL   = 8'd127;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // floor reciprocal of the step count, quotient estimate is at most one low
    localparam logic [MAG_W:0] RECIP = (MAG_W + 1)'((1 << MAG_W) / RAMP_STEPS);

    typedef enum logic [2:0] {
        K_TICK,
        K_LINE_END,
        K_BACKSPACE,
        K_DIGIT,
        K_MINUS,
        K_OTHER
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_MUL,
        S_QUO,
        S_FIX,
        S_PUBLISH
    } state_t;

    typedef struct packed {
        logic [1:0]  pad;
        logic        ramping;
        logic        deadman_tripped;
        logic        command_taken;
        logic [7:0]  throttle_now;
        logic [10:0] pulse_width_us;
    } result_t;

endpackage

[rtl/sthr_front.sv]
// front end: accepts input words, classifies each byte into a command kind
// and holds commands in a short queue for the back end; uses sthr_pkg
module sthr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // rx_byte
    input  logic          s_tuser,   // operation
    output logic          cmd_valid,
    output sthr_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import sthr_pkg::*;

    cmd_t              cls;
    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;

    always_comb
    begin
        cls.digit = s_tdata[3:0];
        if (s_tuser)
            cls.kind = K_TICK;
        else if (s_tdata == CHAR_CR || s_tdata == CHAR_LF)
            cls.kind = K_LINE_END;
        else if (s_tdata == CHAR_BS || s_tdata == CHAR_DEL)
            cls.kind = K_BACKSPACE;
        else if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE)
            cls.kind = K_DIGIT;
        else if (s_tdata == CHAR_MINUS)
            cls.kind = K_MINUS;
        else
            cls.kind = K_OTHER;
    end

    assign s_tready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (!push && cmd_pop)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

[rtl/sthr_back.sv]
// back end: text buffer, decimal conversion, idle timer, deadman ramp and
// the output word register; takes commands from sthr_front, uses sthr_pkg
module sthr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sthr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sthr_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            cmd_valid,
    input  sthr_pkg::cmd_t                  cmd,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sthr_pkg::OUT_W-1:0]      m_tdata
);
    import sthr_pkg::*;

    state_t                 state_reg, state_next;
    logic [3:0]             text_store [TEXT_DEPTH];
    logic                   store_we;
    logic [IDX_W-1:0]       store_addr;
    logic [3:0]             store_data;

    logic [TIMEOUT_W-1:0]   timeout_reg;
    logic [STEP_TICK_W-1:0] step_ticks_reg;

    logic [CNT_W-1:0]       text_count_reg, text_count_next;
    logic [7:0]             throttle_reg, throttle_next;
    logic [TIMEOUT_W-1:0]   idle_reg, idle_next;
    logic                   ramp_active_reg, ramp_active_next;
    logic [STEP_W-1:0]      ramp_index_reg, ramp_index_next;
    logic [STEP_TICK_W-1:0] hold_reg, hold_next;
    logic [7:0]             ramp_val_reg, ramp_val_next;
    logic                   taken_reg, taken_next;
    logic                   tripped_reg, tripped_next;
    logic [IDX_W-1:0]       conv_idx_reg, conv_idx_next;
    logic [6:0]             mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [MAG_W-1:0]       rmag_reg, rmag_next;
    logic                   rneg_reg, rneg_next;
    logic [MAG_W-1:0]       quo_reg, quo_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic [STEP_TICK_W-1:0] hold_plus;
    logic [TIMEOUT_W-1:0]   idle_inc;
    logic [3:0]             conv_digit;
    logic [MCALC_W-1:0]     mag_calc;
    logic [6:0]             mag_upd;
    logic [6:0]             mag_fin;
    logic                   neg_upd;
    logic [PROD_W-1:0]      prod_abs;
    logic [2*MAG_W:0]       quo_wide;
    logic [MAG_W-1:0]       quo_times;
    logic [MAG_W-1:0]       quo_rem;
    logic [MAG_W-1:0]       quo_fix;
    logic [7:0]             now_val;
    logic [11:0]            now_ext;
    logic [11:0]            pulse_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            step_ticks_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:   timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                REG_RAMP_STEP: step_ticks_reg <= cfg_data[STEP_TICK_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            text_store[store_addr] <= store_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_count_reg  <= '0;
            throttle_reg    <= '0;
            idle_reg        <= '0;
            ramp_active_reg <= 1'b0;
            ramp_index_reg  <= '0;
            hold_reg        <= '0;
            ramp_val_reg    <= '0;
            taken_reg       <= 1'b0;
            tripped_reg     <= 1'b0;
            conv_idx_reg    <= '0;
            mag_reg         <= '0;
            neg_reg         <= 1'b0;
            prod_reg        <= '0;
            rmag_reg        <= '0;
            rneg_reg        <= 1'b0;
            quo_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            text_count_reg  <= text_count_next;
            throttle_reg    <= throttle_next;
            idle_reg        <= idle_next;
            ramp_active_reg <= ramp_active_next;
            ramp_index_reg  <= ramp_index_next;
            hold_reg        <= hold_next;
            ramp_val_reg    <= ramp_val_next;
            taken_reg       <= taken_next;
            tripped_reg     <= tripped_next;
            conv_idx_reg    <= conv_idx_next;
            mag_reg         <= mag_next;
            neg_reg         <= neg_next;
            prod_reg        <= prod_next;
            rmag_reg        <= rmag_next;
            rneg_reg        <= rneg_next;
            quo_reg         <= quo_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
        end
    end

    // helpers that do not depend on the state
    always_comb
    begin
        hold_plus  = hold_reg + STEP_TICK_W'(1);
        idle_inc   = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + TIMEOUT_W'(1);
        conv_digit = text_store[conv_idx_reg];
        mag_calc   = MCALC_W'(mag_reg) * MCALC_W'(10) + MCALC_W'(conv_digit);
        if (conv_digit == MINUS_CODE)
        begin
            mag_upd = mag_reg;
            neg_upd = 1'b1;
        end
        else
        begin
            mag_upd = (mag_calc > MCALC_W'(MAG_MAX)) ? MAG_SAT : mag_calc[6:0];
            neg_upd = neg_reg;
        end
        mag_fin   = (mag_upd > MAG_MAX) ? MAG_MAX : mag_upd;
        prod_abs  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        quo_wide  = (2*MAG_W + 1)'(prod_abs[MAG_W-1:0]) * (2*MAG_W + 1)'(RECIP);
        quo_times = MAG_W'(quo_reg * MAG_W'(RAMP_STEPS));
        quo_rem   = rmag_reg - quo_times;
        quo_fix   = (quo_rem >= MAG_W'(RAMP_STEPS)) ? quo_reg + MAG_W'(1) : quo_reg;
        now_val   = ramp_active_reg ? ramp_val_reg : throttle_reg;
        now_ext   = {{4{now_val[7]}}, now_val};
        // 1500 + 5 * throttle, always positive
        pulse_sum = {1'b0, NEUTRAL_US} + (now_ext << 2) + now_ext;
    end

    always_comb
    begin
        state_next       = state_reg;
        text_count_next  = text_count_reg;
        throttle_next    = throttle_reg;
        idle_next        = idle_reg;
        ramp_active_next = ramp_active_reg;
        ramp_index_next  = ramp_index_reg;
        hold_next        = hold_reg;
        ramp_val_next    = ramp_val_reg;
        taken_next       = taken_reg;
        tripped_next     = tripped_reg;
        conv_idx_next    = conv_idx_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        prod_next        = prod_reg;
        rmag_next        = rmag_reg;
        rneg_next        = rneg_reg;
        quo_next         = quo_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        cmd_pop          = 1'b0;
        store_we         = 1'b0;
        store_addr       = text_count_reg[IDX_W-1:0];
        store_data       = cmd.digit;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    taken_next   = 1'b0;
                    tripped_next = 1'b0;
                    state_next   = S_PUBLISH;
                    if (cmd.kind == K_TICK)
                    begin
                        if (ramp_active_reg)
                        begin
                            if (hold_plus >= step_ticks_reg)
                            begin
                                hold_next = '0;
                                if (ramp_index_reg == '0)
                                begin
                                    ramp_active_next = 1'b0;
                                    throttle_next    = '0;
                                    text_count_next  = '0;
                                    idle_next        = '0;
                                end
                                else
                                begin
                                    ramp_index_next = ramp_index_reg - STEP_W'(1);
                                    state_next      = S_MUL;
                                end
                            end
                            else
                            begin
                                hold_next = hold_plus;
                            end
                        end
                        else
                        begin
                            idle_next = idle_inc;
                            if (throttle_reg != '0 && idle_inc > timeout_reg)
                            begin
                                tripped_next     = 1'b1;
                                ramp_active_next = 1'b1;
                                ramp_index_next  = STEP_W'(RAMP_STEPS);
                                hold_next        = '0;
                                state_next       = S_MUL;
                            end
                        end
                    end
                    else if (!ramp_active_reg)
                    begin
                        idle_next = '0;
                        unique case (cmd.kind)
                            K_LINE_END:
                            begin
                                if (text_count_reg != '0)
                                begin
                                    conv_idx_next = '0;
                                    mag_next      = '0;
                                    neg_next      = 1'b0;
                                    state_next    = S_CONV;
                                end
                            end
                            K_BACKSPACE:
                            begin
                                if (text_count_reg != '0)
                                    text_count_next = text_count_reg - CNT_W'(1);
                            end
                            K_DIGIT:
                            begin
                                if (text_count_reg < CNT_W'(TEXT_DEPTH))
                                begin
                                    store_we        = 1'b1;
                                    text_count_next = text_count_reg + CNT_W'(1);
                                end
                            end
                            K_MINUS:
                            begin
                                if (text_count_reg == '0)
                                begin
                                    store_we        = 1'b1;
                                    store_data      = MINUS_CODE;
                                    text_count_next = text_count_reg + CNT_W'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_CONV:
            begin
                // one stored character per cycle
                mag_next = mag_upd;
                neg_next = neg_upd;
                if (CNT_W'(conv_idx_reg) + CNT_W'(1) == text_count_reg)
                begin
                    throttle_next   = neg_upd ? -{1'b0, mag_fin} : {1'b0, mag_fin};
                    text_count_next = '0;
                    taken_next      = 1'b1;
                    state_next      = S_PUBLISH;
                end
                else
                begin
                    conv_idx_next = conv_idx_reg + IDX_W'(1);
                end
            end
            S_MUL:
            begin
                prod_next  = $signed(throttle_reg) * $signed({1'b0, ramp_index_reg});
                state_next = S_QUO;
            end
            S_QUO:
            begin
                rmag_next  = prod_abs[MAG_W-1:0];
                rneg_next  = prod_reg[PROD_W-1];
                quo_next   = quo_wide[2*MAG_W-1:MAG_W];
                state_next = S_FIX;
            end
            S_FIX:
            begin
                ramp_val_next = rneg_reg ? -quo_fix[7:0] : quo_fix[7:0];
                state_next    = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next           = 1'b1;
                    out_next.pad             = '0;
                    out_next.ramping         = ramp_active_reg;
                    out_next.deadman_tripped = tripped_reg;
                    out_next.command_taken   = taken_reg;
                    out_next.throttle_now    = now_val;
                    out_next.pulse_width_us  = pulse_sum[10:0];
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_ramp_has_throttle: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_active_reg |-> (throttle_reg != '0))
        else $error("ramp running with zero throttle");

    a_text_bound: assert property (@(posedge clk) disable iff (!rst_n)
        text_count_reg <= CNT_W'(TEXT_DEPTH))
        else $error("text count beyond buffer depth");

    a_ramp_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_index_reg <= STEP_W'(RAMP_STEPS))
        else $error("ramp index beyond step count");

    a_conv_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> (CNT_W'(conv_idx_reg) < text_count_reg))
        else $error("conversion reads past stored text");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

endmodule

[rtl/serial_throttle_with_deadman_ramp.sv]
// top level of the serial throttle with deadman ramp
// instantiates sthr_front and sthr_back; uses sthr_pkg
//
// usage:
//   s_* carries one word per received serial byte (s_tuser = 0, byte in
//   s_tdata) or per millisecond tick (s_tuser = 1). m_* returns exactly one
//   status word per input word, in order: pulse width, throttle now driven
//   and the taken / tripped / ramping flags.
//   cfg_we writes timeout_ticks (index 0) or ramp_step_ticks (index 1);
//   write only while no word is in flight.
// sequencing:
//   a word is classified into a two-entry command queue, then executed by
//   the back-end sequencer one command at a time. plain bytes and ticks
//   pass the idle and publish states on the way to the output register; a
//   tick that starts or steps the ramp also passes the multiply, reciprocal
//   divide and fix states; a line end converts up to 15 stored characters.
// reset:
//   throttle 0, pulse 1500 us, empty text, timeout 3000, step 25; the text
//   buffer is not cleared and needs no clearing pass.
// stall:
//   the output register holds its word until m_tready; the queue keeps
//   taking words until it is full, then s_tready drops.
module serial_throttle_with_deadman_ramp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  logic                           s_tuser,   // [0] operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [10:0] pulse_width_us, [18:11] throttle_now, [19] command_taken,
    // [20] deadman_tripped, [21] ramping, [23:22] zero
    output logic [sthr_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_we,
    input  logic [sthr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sthr_pkg::CFG_W-1:0]     cfg_data
);
    import sthr_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    sthr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    sthr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench of serial_throttle_with_deadman_ramp: a directed table,
// then random command lines, tick bursts and deadman ramps, checked word by word
// against an in-bench predictor; depends on sthr_pkg and the rtl top level
module tb_top;
    import sthr_pkg::*;

    typedef enum bit {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_e;

    // one input word, with a typed-in status where it can be read off directly
    typedef struct packed {
        op_e         op;
        logic [7:0]  code;
        bit          typed;
        logic [10:0] pulse;
        logic [7:0]  level;
        bit          taken;
    } stim_word_t;

    localparam int HOLD_AT    = 200;
    localparam int HOLD_LEN   = 300;
    localparam int PAUSE_AT   = 400;
    localparam int CALM_FROM  = 450;
    localparam int CALM_TO    = 540;
    localparam int MAX_PRINTS = 40;

    localparam logic [7:0] CH_1 = CHAR_ZERO + 8'd1;
    localparam logic [7:0] CH_5 = CHAR_ZERO + 8'd5;
    localparam logic [7:0] CH_7 = CHAR_ZERO + 8'd7;

    localparam stim_word_t DIRECTED [24] = '{
        '{OP_TICK, 8'h00,      1'b1, 11'd1500, 8'd0,   1'b0},
        '{OP_TICK, 8'hFF,      1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CH_1,       1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_ZERO,  1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_ZERO,  1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_CR,    1'b1, 11'd2000, 8'd100, 1'b1},
        '{OP_BYTE, CHAR_MINUS, 1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_NINE,  1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_NINE,  1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_BS,    1'b0, 11'd0,    8'd0,   1'b0},
        // "-9" -> pulse 1455, throttle -9
        '{OP_BYTE, CHAR_LF,    1'b1, 11'd1455, 8'hF7,  1'b1},
        '{OP_BYTE, CHAR_BS,    1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_DEL,   1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_MINUS, 1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_MINUS, 1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, 8'h00,      1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, 8'hFF,      1'b0, 11'd0,    8'd0,   1'b0},
        // lone minus converts to zero
        '{OP_BYTE, CHAR_CR,    1'b1, 11'd1500, 8'd0,   1'b1},
        // line end on empty text
        '{OP_BYTE, CHAR_LF,    1'b1, 11'd1500, 8'd0,   1'b0},
        '{OP_BYTE, CH_7,       1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_DEL,   1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CH_5,       1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_BYTE, CHAR_CR,    1'b0, 11'd0,    8'd0,   1'b0},
        '{OP_TICK, 8'h5A,      1'b0, 11'd0,    8'd0,   1'b0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] rx_byte
    logic                 s_tuser;   // [0] operation
    logic                 m_tvalid;
    logic                 m_tready;
    // [10:0] pulse_width_us, [18:11] throttle_now, [19] command_taken,
    // [20] deadman_tripped, [21] ramping, [23:22] zero
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // predictor state
    logic [3:0] text_buf [TEXT_DEPTH];
    int         text_len;
    int         held;
    int         idle_ticks;
    bit         ramp_on;
    int         ramp_k;
    int         hold_ticks;
    int         pulse_now;
    int         timeout_cfg;
    int         step_cfg;

    stim_word_t stim_q [$];
    result_t    status_q [$];
    stim_word_t cur_word;
    bit         in_hand = 1'b0;
    bit         paused = 1'b0;
    bit         held_off = 1'b0;
    int         words_sent = 0;
    int         words_seen = 0;
    int         errors = 0;
    int         lines_taken = 0;
    int         trips = 0;
    int         dropped = 0;
    int         settings = 0;

    serial_throttle_with_deadman_ramp i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit calm_now();
        return words_sent >= CALM_FROM && words_sent < CALM_TO;
    endfunction

    function automatic int pulse_for(int level);
        return int'(NEUTRAL_US) + 5 * level;
    endfunction

    function automatic int ramp_level();
        return (held * ramp_k) / RAMP_STEPS;
    endfunction

    function automatic int text_value();
        int mag;
        bit neg;
        mag = 0;
        neg = 1'b0;
        for (int i = 0; i < text_len; i++) begin
            if (text_buf[i] == MINUS_CODE)
            begin
                neg = 1'b1;
            end
            else
            begin
                mag = mag * 10 + int'(text_buf[i]);
                if (mag > 100)
                    mag = 101;
            end
        end
        if (mag > 100)
            mag = 100;
        return neg ? -mag : mag;
    endfunction

    task automatic reset_model();
        text_len    = 0;
        held        = 0;
        idle_ticks  = 0;
        ramp_on     = 1'b0;
        ramp_k      = 0;
        hold_ticks  = 0;
        pulse_now   = int'(NEUTRAL_US);
        timeout_cfg = int'(TIMEOUT_RESET);
        step_cfg    = int'(STEP_RESET);
    endtask

    task automatic predict_status(input op_e op, input logic [7:0] code, output result_t r);
        bit taken;
        bit tripped;
        int level;
        taken   = 1'b0;
        tripped = 1'b0;
        if (op == OP_BYTE)
        begin
            if (ramp_on)
            begin
                dropped++;
            end
            else
            begin
                idle_ticks = 0;
                if (code == CHAR_CR || code == CHAR_LF)
                begin
                    if (text_len > 0)
                    begin
                        held      = text_value();
                        text_len  = 0;
                        pulse_now = pulse_for(held);
                        taken     = 1'b1;
                    end
                end
                else if ((code == CHAR_BS || code == CHAR_DEL) && text_len > 0)
                begin
                    text_len--;
                end
                else if (text_len < TEXT_DEPTH)
                begin
                    if (code >= CHAR_ZERO && code <= CHAR_NINE)
                    begin
                        text_buf[text_len] = 4'(code - CHAR_ZERO);
                        text_len++;
                    end
                    else if (code == CHAR_MINUS && text_len == 0)
                    begin
                        text_buf[0] = MINUS_CODE;
                        text_len    = 1;
                    end
                end
            end
        end
        else if (ramp_on)
        begin
            hold_ticks++;
            // a step length of zero acts as one
            if (hold_ticks >= step_cfg)
            begin
                hold_ticks = 0;
                if (ramp_k == 0)
                begin
                    ramp_on    = 1'b0;
                    held       = 0;
                    text_len   = 0;
                    idle_ticks = 0;
                    pulse_now  = int'(NEUTRAL_US);
                end
                else
                begin
                    ramp_k--;
                    pulse_now = pulse_for(ramp_level());
                end
            end
        end
        else
        begin
            if (idle_ticks < int'(IDLE_MAX))
                idle_ticks++;
            if (held != 0 && idle_ticks > timeout_cfg)
            begin
                tripped    = 1'b1;
                ramp_on    = 1'b1;
                ramp_k     = RAMP_STEPS;
                hold_ticks = 0;
                pulse_now  = pulse_for(ramp_level());
            end
        end
        level = ramp_on ? ramp_level() : held;
        lines_taken += taken;
        trips       += tripped;
        r = '0;
        r.pulse_width_us  = 11'(pulse_now);
        r.throttle_now    = 8'(level);
        r.command_taken   = taken;
        r.deadman_tripped = tripped;
        r.ramping         = ramp_on;
    endtask

    task automatic report_mismatch(string what, int got_v, int want_v);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("status word %0d: %s is %0d, predicted %0d", words_seen, what, got_v, want_v);
    endtask

    // ---------------- stimulus building ----------------

    task automatic push_word(op_e op, logic [7:0] code);
        stim_word_t w;
        w = '0;
        w.op   = op;
        w.code = code;
        stim_q.push_back(w);
    endtask

    task automatic add_ticks(int n);
        for (int i = 0; i < n; i++)
            push_word(OP_TICK, 8'($urandom_range(255)));
    endtask

    // a command line: optional minus, digits, now and then a correction
    task automatic add_line(bit nonzero);
        int n;
        int d;
        if ($urandom_range(1))
            push_word(OP_BYTE, CHAR_MINUS);
        n = ($urandom_range(9) == 0) ? $urandom_range(4, 18) : $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            d = (i == 0 && nonzero) ? $urandom_range(1, 9) : $urandom_range(0, 9);
            push_word(OP_BYTE, CHAR_ZERO + 8'(d));
            if (!nonzero && $urandom_range(14) == 0)
                push_word(OP_BYTE, $urandom_range(1) ? CHAR_BS : CHAR_DEL);
        end
        push_word(OP_BYTE, $urandom_range(1) ? CHAR_CR : CHAR_LF);
    endtask

    task automatic add_noise();
        case ($urandom_range(4))
            0: push_word(OP_BYTE, 8'($urandom_range(255)));
            1: push_word(OP_BYTE, CHAR_BS);
            2: push_word(OP_BYTE, CHAR_DEL);
            3: push_word(OP_BYTE, CHAR_MINUS);
            default: push_word(OP_BYTE, $urandom_range(1) ? CHAR_CR : CHAR_LF);
        endcase
    endtask

    // nonzero command, silence past the timeout, then part or all of the ramp
    task automatic add_trip();
        int step_eff;
        int n;
        step_eff = (step_cfg == 0) ? 1 : step_cfg;
        add_line(1'b1);
        add_ticks(timeout_cfg + 1);
        n = $urandom_range(0, (RAMP_STEPS + 1) * step_eff + 2);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) == 0)
                push_word(OP_BYTE, 8'($urandom_range(255)));
            push_word(OP_TICK, 8'($urandom_range(255)));
        end
    endtask

    // ---------------- sequencing ----------------

    task automatic drain();
        while (stim_q.size() != 0 || in_hand || status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
    endtask

    task automatic set_config(int tmo, int stp);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_RAMP_STEP, stp);
        @(posedge clk);
        cfg_we <= 1'b0;
        timeout_cfg = tmo;
        step_cfg    = stp;
        settings++;
    endtask

    task automatic run_phase(int tmo, int stp, int n_words);
        int roll;
        set_config(tmo, stp);
        while (stim_q.size() < n_words) begin
            roll = $urandom_range(99);
            if (roll < 40)
                add_line(1'b0);
            else if (roll < 60)
                add_ticks($urandom_range(1, 6));
            else if (roll < 75 && tmo <= 40)
                add_trip();
            else
                add_noise();
        end
        drain();
    endtask

    // ---------------- processes ----------------

    initial
    begin : word_source
        result_t pred;
        result_t want;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        forever begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                predict_status(cur_word.op, cur_word.code, pred);
                if (cur_word.typed)
                begin
                    want = '0;
                    want.pulse_width_us = cur_word.pulse;
                    want.throttle_now   = cur_word.level;
                    want.command_taken  = cur_word.taken;
                end
                else
                begin
                    want = pred;
                end
                status_q.push_back(want);
                words_sent++;
                in_hand = 1'b0;
            end
            if (!s_tvalid || s_tready)
            begin
                if (!paused && words_sent >= PAUSE_AT)
                begin
                    // hold back until every status word is back
                    paused = 1'b1;
                    s_tvalid <= 1'b0;
                    while (status_q.size() != 0)
                        @(posedge clk);
                end
                else if (stim_q.size() != 0 && (calm_now() || $urandom_range(99) >= 25))
                begin
                    cur_word = stim_q.pop_front();
                    in_hand  = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_word.code;
                    s_tuser  <= cur_word.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    initial
    begin : status_sink
        int hold_cnt;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held_off && words_sent >= HOLD_AT)
            begin
                // long back-pressure so the queue fills and s_tready drops
                held_off = 1'b1;
                m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_LEN) begin
                    @(posedge clk);
                    hold_cnt++;
                end
            end
            else
            begin
                m_tready <= calm_now() || ($urandom_range(99) >= 25);
            end
        end
    end

    initial
    begin : status_check
        result_t got;
        result_t want;
        forever begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                got = result_t'(m_tdata);
                if (status_q.size() == 0)
                begin
                    report_mismatch("word with none pending, pulse_width_us",
                                    int'(got.pulse_width_us), 0);
                end
                else
                begin
                    want = status_q.pop_front();
                    if (got.pulse_width_us !== want.pulse_width_us)
                        report_mismatch("pulse_width_us", int'(got.pulse_width_us),
                                        int'(want.pulse_width_us));
                    if (got.throttle_now !== want.throttle_now)
                        report_mismatch("throttle_now", int'($signed(got.throttle_now)),
                                        int'($signed(want.throttle_now)));
                    if (got.command_taken !== want.command_taken)
                        report_mismatch("command_taken", int'(got.command_taken),
                                        int'(want.command_taken));
                    if (got.deadman_tripped !== want.deadman_tripped)
                        report_mismatch("deadman_tripped", int'(got.deadman_tripped),
                                        int'(want.deadman_tripped));
                    if (got.ramping !== want.ramping)
                        report_mismatch("ramping", int'(got.ramping), int'(want.ramping));
                end
                words_seen++;
            end
        end
    end

    initial
    begin : watchdog
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : run_main
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= '0;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table under the reset settings
        for (int i = 0; i < $size(DIRECTED); i++)
            stim_q.push_back(DIRECTED[i]);
        drain();

        run_phase(5, 1, 120);
        run_phase(1, 0, 80);
        // widest settings: the deadman cannot fire
        run_phase(int'(IDLE_MAX), 1023, 60);

        // trip with the longest step, leave the ramp running, then shorten it
        set_config(8, 1023);
        push_word(OP_BYTE, CH_5);
        push_word(OP_BYTE, CHAR_ZERO);
        push_word(OP_BYTE, CHAR_CR);
        add_ticks(14);
        push_word(OP_BYTE, CH_1);
        push_word(OP_BYTE, CHAR_CR);
        add_ticks(3);
        drain();
        run_phase(8, 2, 120);

        for (int i = 0; i < 3; i++)
            run_phase($urandom_range(2, 20), $urandom_range(1, 4), 80);
        run_phase(0, 3, 60);

        repeat (20) @(posedge clk);
        $display("ran %0d words over %0d register settings: %0d throttle commands,",
                 words_sent, settings, lines_taken);
        $display("%0d deadman trips, %0d bytes dropped during ramps, %0d mismatches",
                 trips, dropped, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
